// ----- hdl/gepr_pkg.sv -----
`default_nettype none

package gepr_pkg;

    localparam int EDGE_W    = 32;
    localparam int CODE_W    = 10;
    localparam int VALUE_W   = 32;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 1;
    localparam int MOVE_W    = 3;
    localparam int BTN_W     = 8;
    localparam int ENTRY_W   = 2 * MOVE_W + 1 + BTN_W;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    localparam logic [OP_W-1:0] OP_SYNC = 2'd0;
    localparam logic [OP_W-1:0] OP_KEY  = 2'd1;
    localparam logic [OP_W-1:0] OP_REL  = 2'd2;
    localparam logic [OP_W-1:0] OP_READ = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_EDGE_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_LOW  = 1'b1;

    localparam logic [CODE_W-1:0] SYNC_FRAME = 10'h000;
    localparam logic [CODE_W-1:0] REL_X      = 10'h000;
    localparam logic [CODE_W-1:0] REL_Y      = 10'h001;

    localparam logic [CODE_W-1:0] BTN_A      = 10'h130;
    localparam logic [CODE_W-1:0] BTN_B      = 10'h131;
    localparam logic [CODE_W-1:0] BTN_X      = 10'h133;
    localparam logic [CODE_W-1:0] BTN_Y      = 10'h134;
    localparam logic [CODE_W-1:0] BTN_LSTICK = 10'h13D;
    localparam logic [CODE_W-1:0] BTN_RSTICK = 10'h13E;
    localparam logic [CODE_W-1:0] BTN_MENU   = 10'h13B;
    localparam logic [CODE_W-1:0] BTN_SELECT = 10'h116;

    localparam logic signed [VALUE_W-1:0] KEY_RELEASE = 32'sd0;
    localparam logic signed [VALUE_W-1:0] KEY_REPEAT  = 32'sd2;

    localparam logic signed [MOVE_W-1:0] MOVE_POS  = 3'sb010;
    localparam logic signed [MOVE_W-1:0] MOVE_NEG  = 3'sb110;
    localparam logic signed [MOVE_W-1:0] MOVE_ZERO = 3'sb000;

    localparam logic signed [EDGE_W-1:0] EDGE_HIGH_RST = 32'sd32767;
    localparam logic signed [EDGE_W-1:0] EDGE_LOW_RST  = -32'sd32768;

    typedef struct packed {
        logic           hit;
        logic [2:0]     idx;
    } btn_sel_t;

    typedef struct packed {
        logic [BTN_W-1:0]              buttons;
        logic                          moved;
        logic signed [MOVE_W-1:0]      dy;
        logic signed [MOVE_W-1:0]      dx;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic rd_load;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic op_read;
    } dp_status_t;

    function automatic btn_sel_t button_sel(input logic [CODE_W-1:0] code);
        btn_sel_t s;
        s.hit = 1'b1;
        s.idx = 3'd0;
        case (code)
            BTN_A:      s.idx = 3'd0;
            BTN_B:      s.idx = 3'd1;
            BTN_X:      s.idx = 3'd2;
            BTN_Y:      s.idx = 3'd3;
            BTN_LSTICK: s.idx = 3'd4;
            BTN_RSTICK: s.idx = 3'd5;
            BTN_MENU:   s.idx = 3'd6;
            BTN_SELECT: s.idx = 3'd7;
            default:    s.hit = 1'b0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/gamepad_event_packet_ring.sv -----
// Gamepad event packet ring.
// Input stream: one event per beat. s_tuser carries the op (sync, key, relative
// move, read); s_tdata carries the event code and value. Key and move events
// update the current packet; a sync report commits it to the ring; a read pops
// the oldest queued packet. Every accepted beat yields exactly one output beat.
// Config port: cfg_we/cfg_index/cfg_data write edge_high (0) or edge_low (1);
// write only while no beat is in flight.
// Results: key, move and sync beats give their result in the cycle after
// acceptance; a read beat goes through the registered ring memory read and then
// the output register. Key, move and sync beats may be accepted every cycle
// while the output is not held; a read holds off new beats until it completes.
// Reset: state clears and the edges return to their reset values; the ring memory
// is then zeroed one entry per cycle, with s_tready low until every entry is done.
// Stall: the result sits in an output register; while it is held (m_tready low)
// no new beat is accepted. A beat taken in the same cycle the held result drains
// is accepted.

`default_nettype none

module gamepad_event_packet_ring #(
    parameter int RING_DEPTH = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // [9:0] code, [41:10] value, [47:42] zero
    input  wire logic [gepr_pkg::IN_DATA_W-1:0]       s_tdata,
    // [1:0] op
    input  wire logic [gepr_pkg::OP_W-1:0]            s_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // [0] popped, [3:1] out_dx, [6:4] out_dy, [7] out_moved,
    // [15:8] out_buttons, [16] notify, [23:17] zero
    output logic      [gepr_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                                 cfg_we,
    input  wire logic [gepr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [gepr_pkg::EDGE_W-1:0]          cfg_data
);
    import gepr_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    gepr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gepr_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !s_tready)
        else $error("beat accepted during ring clear");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == OP_READ)) |=> ##1 m_tvalid)
        else $error("read beat produced no result");

    a_pop_xor_notify: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[16]))
        else $error("pop and notify in one result");

    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[15:1] == 15'd0))
        else $error("entry fields set without a pop");

endmodule

`default_nettype wire

// ----- hdl/gepr_ctrl.sv -----
`default_nettype none

module gepr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire gepr_pkg::dp_status_t status,
    output gepr_pkg::ctrl_cmd_t       cmd
);
    import gepr_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    // output slot is free when empty or drained this cycle
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        cmd.clr_step = (state_reg == ST_CLEAR);
        cmd.accept   = accept;
        cmd.rd_load  = (state_reg == ST_READ);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (status.op_read)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/gepr_dp.sv -----
`default_nettype none

module gepr_dp #(
    parameter int RING_DEPTH = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [gepr_pkg::IN_DATA_W-1:0]        s_tdata,
    input  wire logic [gepr_pkg::OP_W-1:0]             s_tuser,
    output logic      [gepr_pkg::OUT_DATA_W-1:0]       m_tdata,
    input  wire logic                                  cfg_we,
    input  wire logic [gepr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [gepr_pkg::EDGE_W-1:0]           cfg_data,
    input  wire gepr_pkg::ctrl_cmd_t                   cmd,
    output gepr_pkg::dp_status_t                       status
);
    import gepr_pkg::*;

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    logic signed [EDGE_W-1:0]  edge_high_reg, edge_low_reg;
    logic signed [MOVE_W-1:0]  cur_dx_reg, cur_dx_next;
    logic signed [MOVE_W-1:0]  cur_dy_reg, cur_dy_next;
    logic                      cur_moved_reg, cur_moved_next;
    logic [BTN_W-1:0]          cur_buttons_reg, cur_buttons_next;
    logic [BTN_W-1:0]          newest_btn_reg, newest_btn_next;
    logic [PTR_W-1:0]          write_pos_reg, write_pos_next;
    logic [PTR_W-1:0]          read_pos_reg, read_pos_next;
    logic                      ready_reg, ready_next;
    logic [PTR_W-1:0]          clr_cnt_reg;
    logic                      pop_reg, pop_next;

    entry_t                    ring_mem [RING_DEPTH];
    entry_t                    mem_rd_reg;
    logic                      mem_we, mem_re;
    logic [PTR_W-1:0]          mem_waddr;
    entry_t                    mem_wdata;

    logic [OUT_DATA_W-1:0]     out_data_reg;

    logic [OP_W-1:0]           op;
    logic [CODE_W-1:0]         code;
    logic signed [VALUE_W-1:0] value;
    btn_sel_t                  bsel;
    logic signed [MOVE_W-1:0]  qmove;
    logic [PTR_W-1:0]          wp_inc, rp_inc;
    logic                      advance, sync_report, notify;
    entry_t                    cur_entry;

    assign op    = s_tuser;
    assign code  = s_tdata[CODE_W-1:0];
    assign value = s_tdata[CODE_W +: VALUE_W];
    assign bsel  = button_sel(code);

    assign status.clr_done = (clr_cnt_reg == PTR_LAST);
    assign status.op_read  = (op == OP_READ);

    always_comb
    begin
        if (value >= edge_high_reg)
        begin
            qmove = MOVE_POS;
        end
        else if (value <= edge_low_reg)
        begin
            qmove = MOVE_NEG;
        end
        else
        begin
            qmove = MOVE_ZERO;
        end
    end

    assign wp_inc      = ptr_inc(write_pos_reg);
    assign rp_inc      = ptr_inc(read_pos_reg);
    assign sync_report = cmd.accept && (op == OP_SYNC) && (code == SYNC_FRAME);
    // newest_btn_reg mirrors the buttons of the slot at write_pos
    assign advance     = (cur_moved_reg || (newest_btn_reg != cur_buttons_reg))
                         && (wp_inc != read_pos_reg);

    assign cur_entry.dx      = cur_dx_reg;
    assign cur_entry.dy      = cur_dy_reg;
    assign cur_entry.moved   = cur_moved_reg;
    assign cur_entry.buttons = cur_buttons_reg;

    always_comb
    begin
        cur_dx_next      = cur_dx_reg;
        cur_dy_next      = cur_dy_reg;
        cur_moved_next   = cur_moved_reg;
        cur_buttons_next = cur_buttons_reg;
        newest_btn_next  = newest_btn_reg;
        write_pos_next   = write_pos_reg;
        read_pos_next    = read_pos_reg;
        ready_next       = ready_reg;
        pop_next         = pop_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_waddr        = write_pos_reg;
        mem_wdata        = cur_entry;
        notify           = 1'b0;

        if (cmd.clr_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (cmd.accept)
        begin
            case (op)
                OP_KEY:
                begin
                    if (bsel.hit && (value != KEY_REPEAT))
                    begin
                        cur_buttons_next[bsel.idx] = (value != KEY_RELEASE);
                    end
                end
                OP_REL:
                begin
                    if (code == REL_X)
                    begin
                        cur_dx_next = qmove;
                    end
                    else if (code == REL_Y)
                    begin
                        cur_dy_next = qmove;
                    end
                    cur_moved_next = (cur_dx_next != MOVE_ZERO) || (cur_dy_next != MOVE_ZERO);
                end
                OP_SYNC:
                begin
                    if (sync_report)
                    begin
                        if (advance)
                        begin
                            write_pos_next = wp_inc;
                            ready_next     = 1'b1;
                        end
                        mem_we          = 1'b1;
                        mem_waddr       = write_pos_next;
                        newest_btn_next = cur_buttons_reg;
                        notify          = ready_next && (write_pos_next != read_pos_reg);
                        cur_dx_next     = MOVE_ZERO;
                        cur_dy_next     = MOVE_ZERO;
                        cur_moved_next  = 1'b0;
                    end
                end
                OP_READ:
                begin
                    if (write_pos_reg != read_pos_reg)
                    begin
                        read_pos_next = rp_inc;
                        mem_re        = 1'b1;
                        pop_next      = 1'b1;
                    end
                    else
                    begin
                        ready_next = 1'b0;
                        pop_next   = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_high_reg   <= EDGE_HIGH_RST;
            edge_low_reg    <= EDGE_LOW_RST;
            cur_dx_reg      <= MOVE_ZERO;
            cur_dy_reg      <= MOVE_ZERO;
            cur_moved_reg   <= 1'b0;
            cur_buttons_reg <= '0;
            newest_btn_reg  <= '0;
            write_pos_reg   <= '0;
            read_pos_reg    <= '0;
            ready_reg       <= 1'b0;
            clr_cnt_reg     <= '0;
            pop_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_EDGE_HIGH: edge_high_reg <= cfg_data;
                    REG_EDGE_LOW:  edge_low_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            cur_dx_reg      <= cur_dx_next;
            cur_dy_reg      <= cur_dy_next;
            cur_moved_reg   <= cur_moved_next;
            cur_buttons_reg <= cur_buttons_next;
            newest_btn_reg  <= newest_btn_next;
            write_pos_reg   <= write_pos_next;
            read_pos_reg    <= read_pos_next;
            ready_reg       <= ready_next;
            pop_reg         <= pop_next;
            if (cmd.clr_step && !status.clr_done)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rd_reg <= ring_mem[read_pos_next];
        end
    end

    // beat layout: pop flag, dx, dy, moved, buttons, notify, zero pad
    always_ff @(posedge clk)
    begin
        if (cmd.rd_load)
        begin
            if (pop_reg)
            begin
                out_data_reg <= {7'd0, 1'b0, mem_rd_reg.buttons, mem_rd_reg.moved,
                                 mem_rd_reg.dy, mem_rd_reg.dx, 1'b1};
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
        else if (cmd.accept && (op != OP_READ))
        begin
            out_data_reg <= {7'd0, notify, 16'd0};
        end
    end

    assign m_tdata = out_data_reg;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gepr_pkg::*;

    localparam int RING_DEPTH = 64;
    localparam int PHASE_EVENTS = 260;
    localparam logic [OUT_DATA_W-1:0] NO_RESULT = '0;

    typedef struct {
        logic [OP_W-1:0]       op;
        logic [CODE_W-1:0]     code;
        logic [VALUE_W-1:0]    value;
        bit                    known;
        logic [OUT_DATA_W-1:0] known_res;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [EDGE_W-1:0]     cfg_data = '0;

    // predictor state
    logic signed [EDGE_W-1:0] edge_hi = EDGE_HIGH_RST;
    logic signed [EDGE_W-1:0] edge_lo = EDGE_LOW_RST;
    entry_t                   pkt = '0;
    entry_t                   ring [RING_DEPTH];
    int                       wr_ptr = 0;
    int                       rd_ptr = 0;
    bit                       ready = 1'b0;

    logic [OUT_DATA_W-1:0] pending_reports [$];
    int                    mismatches = 0;
    int                    sent = 0;
    bit                    quiet = 1'b0;
    int                    stall_left = 0;
    int                    stall_pick;

    logic [CODE_W-1:0] button_codes [8] = '{BTN_A, BTN_B, BTN_X, BTN_Y,
                                            BTN_LSTICK, BTN_RSTICK, BTN_MENU, BTN_SELECT};

    stim_row_t dir_rows [27] = '{
        '{OP_READ, 10'h000,     32'h0000_0000, 1'b1, NO_RESULT},
        '{OP_SYNC, SYNC_FRAME,  32'h0000_0000, 1'b1, NO_RESULT},
        '{OP_KEY,  BTN_A,       32'h0000_0001, 1'b1, NO_RESULT},
        '{OP_KEY,  BTN_B,       KEY_REPEAT,    1'b1, NO_RESULT},
        '{OP_KEY,  BTN_SELECT,  32'h8000_0000, 1'b1, NO_RESULT},
        '{OP_KEY,  10'h3FF,     32'h0000_0001, 1'b1, NO_RESULT},
        '{OP_SYNC, SYNC_FRAME,  32'h0000_0000, 1'b0, NO_RESULT},
        '{OP_REL,  REL_X,       32'h7FFF_FFFF, 1'b1, NO_RESULT},
        '{OP_REL,  REL_Y,       32'h8000_0000, 1'b1, NO_RESULT},
        '{OP_REL,  10'h2AA,     32'hFFFF_FFFF, 1'b1, NO_RESULT},
        '{OP_SYNC, 10'h155,     32'h0000_0000, 1'b1, NO_RESULT},
        '{OP_SYNC, SYNC_FRAME,  32'h0000_0000, 1'b0, NO_RESULT},
        '{OP_REL,  REL_X,       32'd32766,     1'b1, NO_RESULT},
        '{OP_REL,  REL_Y,       -32'sd32767,   1'b1, NO_RESULT},
        '{OP_SYNC, SYNC_FRAME,  32'h0000_0000, 1'b0, NO_RESULT},
        '{OP_KEY,  BTN_A,       KEY_RELEASE,   1'b1, NO_RESULT},
        '{OP_KEY,  BTN_X,       32'hFFFF_FFFF, 1'b1, NO_RESULT},
        '{OP_KEY,  BTN_Y,       32'h0000_0001, 1'b1, NO_RESULT},
        '{OP_KEY,  BTN_LSTICK,  32'h0000_0001, 1'b1, NO_RESULT},
        '{OP_KEY,  BTN_RSTICK,  32'h0000_0001, 1'b1, NO_RESULT},
        '{OP_KEY,  BTN_MENU,    32'h0000_0001, 1'b1, NO_RESULT},
        '{OP_SYNC, SYNC_FRAME,  32'h0000_0000, 1'b0, NO_RESULT},
        '{OP_READ, 10'h000,     32'h0000_0000, 1'b0, NO_RESULT},
        '{OP_READ, 10'h000,     32'h0000_0000, 1'b0, NO_RESULT},
        '{OP_READ, 10'h000,     32'h0000_0000, 1'b0, NO_RESULT},
        '{OP_READ, 10'h000,     32'h0000_0000, 1'b0, NO_RESULT},
        // buttons unchanged against an already popped newest slot
        '{OP_SYNC, SYNC_FRAME,  32'h0000_0000, 1'b0, NO_RESULT}
    };

    gamepad_event_packet_ring #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int btn_bit(logic [CODE_W-1:0] code);
        case (code)
            BTN_A:      return 0;
            BTN_B:      return 1;
            BTN_X:      return 2;
            BTN_Y:      return 3;
            BTN_LSTICK: return 4;
            BTN_RSTICK: return 5;
            BTN_MENU:   return 6;
            BTN_SELECT: return 7;
            default:    return -1;
        endcase
    endfunction

    function automatic logic signed [MOVE_W-1:0] quantize(logic signed [VALUE_W-1:0] v);
        if (v >= edge_hi)
            return MOVE_POS;
        if (v <= edge_lo)
            return MOVE_NEG;
        return MOVE_ZERO;
    endfunction

    function automatic int ring_level();
        return (wr_ptr - rd_ptr + RING_DEPTH) % RING_DEPTH;
    endfunction

    // advances the predicted state by one event and returns the result beat
    function automatic logic [OUT_DATA_W-1:0] next_report(logic [OP_W-1:0] op,
                                                          logic [CODE_W-1:0] code,
                                                          logic signed [VALUE_W-1:0] value);
        logic [OUT_DATA_W-1:0] res;
        int                    b;
        int                    slot;
        int                    nxt;
        entry_t                e;
        res = '0;
        case (op)
            OP_KEY:
            begin
                b = btn_bit(code);
                if (value != KEY_REPEAT && b >= 0)
                    pkt.buttons[b] = (value != KEY_RELEASE);
            end
            OP_REL:
            begin
                if (code == REL_X)
                    pkt.dx = quantize(value);
                else if (code == REL_Y)
                    pkt.dy = quantize(value);
                pkt.moved = (pkt.dx != MOVE_ZERO || pkt.dy != MOVE_ZERO);
            end
            OP_SYNC:
            begin
                if (code == SYNC_FRAME)
                begin
                    slot = wr_ptr;
                    if (pkt.moved || ring[wr_ptr].buttons != pkt.buttons)
                    begin
                        nxt = (wr_ptr + 1) % RING_DEPTH;
                        // full ring: newest entry is overwritten instead
                        if (nxt != rd_ptr)
                        begin
                            wr_ptr = nxt;
                            slot = nxt;
                            ready = 1'b1;
                        end
                    end
                    ring[slot] = pkt;
                    res[16] = ready && (wr_ptr != rd_ptr);
                    pkt.dx = MOVE_ZERO;
                    pkt.dy = MOVE_ZERO;
                    pkt.moved = 1'b0;
                end
            end
            default:
            begin
                if (wr_ptr != rd_ptr)
                begin
                    rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                    e = ring[rd_ptr];
                    res[0] = 1'b1;
                    res[3:1] = e.dx;
                    res[6:4] = e.dy;
                    res[7] = e.moved;
                    res[15:8] = e.buttons;
                end
                else
                    ready = 1'b0;
            end
        endcase
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CODE_W-1:0] rand_key_code();
        if ($urandom_range(0, 99) < 85)
            return button_codes[$urandom_range(0, 7)];
        return CODE_W'($urandom);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_key_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 32'd1;
        if (r < 75)
            return KEY_RELEASE;
        if (r < 85)
            return KEY_REPEAT;
        return $urandom;
    endfunction

    function automatic logic [CODE_W-1:0] rand_axis();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return REL_X;
        if (r < 90)
            return REL_Y;
        return CODE_W'($urandom);
    endfunction

    // distances cluster around the current edges, with zero, the extremes and random values mixed in
    function automatic logic [VALUE_W-1:0] rand_move();
        case ($urandom_range(0, 9))
            0: return edge_hi;
            1: return edge_hi - 1;
            2: return edge_lo;
            3: return edge_lo + 1;
            4: return 32'h0;
            5: return 32'h7FFF_FFFF;
            6: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_event(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                              input logic [VALUE_W-1:0] value, input bit known = 1'b0,
                              input logic [OUT_DATA_W-1:0] known_res = '0);
        int                    gap;
        logic [OUT_DATA_W-1:0] r;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {{(IN_DATA_W - VALUE_W - CODE_W){1'b0}}, value, code};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = next_report(op, code, value);
        pending_reports.push_back(known ? known_res : r);
        sent++;
        if (sent % 64 == 0)
            quiet = ($urandom_range(0, 3) == 0);
    endtask

    task automatic send_packet(input int n_keys, input int n_moves, input bit report);
        repeat (n_keys) send_event(OP_KEY, rand_key_code(), rand_key_value());
        repeat (n_moves) send_event(OP_REL, rand_axis(), rand_move());
        send_event(OP_SYNC, report ? SYNC_FRAME : CODE_W'($urandom), $urandom);
    endtask

    task automatic set_edges(input logic [EDGE_W-1:0] hi, input logic [EDGE_W-1:0] lo);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_EDGE_HIGH;
        cfg_data <= hi;
        edge_hi = hi;
        @(posedge clk);
        cfg_index <= REG_EDGE_LOW;
        cfg_data <= lo;
        edge_lo = lo;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic note_mismatch(input string what, input logic [OUT_DATA_W-1:0] want,
                                 input logic [OUT_DATA_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t mismatch (%s)", $time, what);
            $display("  exp have=%0d dx=%0d dy=%0d moved=%0d btn=%02h ntf=%0d pad=%02h",
                     want[0], $signed(want[3:1]), $signed(want[6:4]), want[7], want[15:8],
                     want[16], want[23:17]);
            $display("  got have=%0d dx=%0d dy=%0d moved=%0d btn=%02h ntf=%0d pad=%02h",
                     got[0], $signed(got[3:1]), $signed(got[6:4]), got[7], got[15:8],
                     got[16], got[23:17]);
        end
    endtask

    always @(posedge clk)
    begin
        if (quiet)
        begin
            stall_left = 0;
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 12)
                stall_left = $urandom_range(0, 2);
            else if (stall_pick < 14)
                stall_left = $urandom_range(10, 40);
            m_tready <= (stall_pick >= 14);
        end
    end

    always @(posedge clk)
    begin
        logic [OUT_DATA_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_reports.size() == 0)
                note_mismatch("unexpected beat", '0, m_tdata);
            else
            begin
                want = pending_reports.pop_front();
                if (m_tdata[0] !== want[0] || m_tdata[3:1] !== want[3:1]
                    || m_tdata[6:4] !== want[6:4] || m_tdata[7] !== want[7]
                    || m_tdata[15:8] !== want[15:8] || m_tdata[16] !== want[16]
                    || m_tdata[23:17] !== want[23:17])
                    note_mismatch("field", want, m_tdata);
            end
        end
    end

    initial
    begin
        int ph;
        int start;
        int guard;
        int r;
        for (int i = 0; i < RING_DEPTH; i++)
            ring[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_event(dir_rows[i].op, dir_rows[i].code, dir_rows[i].value,
                       dir_rows[i].known, dir_rows[i].known_res);

        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                1: set_edges(32'h7FFF_FFFF, 32'h8000_0000);
                2: set_edges(32'h8000_0000, 32'h7FFF_FFFF);
                3: set_edges(32'd1, 32'hFFFF_FFFF);
                4: set_edges($urandom, $urandom);
                default: ;
            endcase
            start = sent;
            // fill without reads until the ring is full, then a few more
            guard = 0;
            while (ring_level() < RING_DEPTH - 1 && guard < 200)
            begin
                send_event(OP_REL, REL_X, rand_move());
                send_packet($urandom_range(0, 1), 1, 1'b1);
                guard++;
            end
            repeat (5) send_packet(1, 1, 1'b1);
            while (sent - start < PHASE_EVENTS)
            begin
                r = $urandom_range(0, 99);
                if (r < 22)
                    send_event(OP_READ, CODE_W'($urandom), $urandom);
                else if (r < 30)
                    send_event(OP_W'($urandom), CODE_W'($urandom), $urandom);
                else
                    send_packet($urandom_range(0, 3), $urandom_range(0, 2),
                                $urandom_range(0, 9) != 0);
            end
            while (ring_level() != 0)
                send_event(OP_READ, CODE_W'($urandom), $urandom);
            send_event(OP_READ, CODE_W'($urandom), $urandom);
        end

        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// ----- gamepad_event_packet_ring.f -----
hdl/gepr_pkg.sv
hdl/gepr_ctrl.sv
hdl/gepr_dp.sv
hdl/gamepad_event_packet_ring.sv
verif/tb.sv
